// ===== sv/mlprq_pkg.sv =====
package mlprq_pkg;

    localparam int DEF_PROCESS_SLOTS   = 64;
    localparam int DEF_PRIORITY_LEVELS = 5;

    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int NPRI_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int PRI_OUT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_ENQ  = 2'd1,
        CMD_DEQ  = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_QUEUED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        LVOP_NONE,
        LVOP_UNLINK,
        LVOP_APPEND
    } t_lv_op;

    typedef enum logic [1:0] {
        LVSEL_DEQ,
        LVSEL_OLD,
        LVSEL_NEW
    } t_lv_sel;

    typedef enum logic [1:0] {
        PRI_ZERO,
        PRI_DEQ,
        PRI_OLD,
        PRI_NEW
    } t_pri_sel;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_ECHO,
        SLOT_X
    } t_slot_sel;

    typedef struct packed {
        logic      capture;
        logic      fetch;
        t_lv_op    lv_op;
        t_lv_sel   lv_sel;
        logic      lvl_wr;
        logic      lvl_inq;
        logic      res_load;
        t_status   res_status;
        t_slot_sel res_slot;
        t_pri_sel  res_pri;
        logic      load_out;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic slot_ok;
        logic np_ok;
        logic inq;
        logic any_queued;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/mlprq_if.sv =====
interface mlprq_cmd_if;
    import mlprq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [NPRI_W-1:0] req_priority;

    modport source(output valid, command, slot, req_priority, input ready);
    modport sink(input valid, command, slot, req_priority, output ready);
endinterface

interface mlprq_res_if;
    import mlprq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot_out;
    logic [PRI_OUT_W-1:0] priority_out;

    modport source(output valid, status, slot_out, priority_out, input ready);
    modport sink(input valid, status, slot_out, priority_out, output ready);
endinterface

// ===== sv/mlprq_ram.sv =====
module mlprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== sv/mlprq_ctrl.sv =====
module mlprq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mlprq_pkg::t_dp_stat i_stat,
    output mlprq_pkg::t_ctl     o_ctl
);
    import mlprq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_APPEND,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_ctl.fetch = 1'b1;
                if (i_stat.cmd == CMD_DEQ && !i_stat.any_queued) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = ST_EMPTY;
                    o_ctl.res_slot   = SLOT_ZERO;
                    o_ctl.res_pri    = PRI_ZERO;
                    n_state          = S_HOLD;
                end else if (i_stat.cmd != CMD_DEQ && !i_stat.slot_ok) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = ST_OK;
                    o_ctl.res_slot   = SLOT_ECHO;
                    o_ctl.res_pri    = PRI_ZERO;
                    n_state          = S_HOLD;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.res_load   = 1'b1;
                o_ctl.res_status = ST_OK;
                o_ctl.res_slot   = SLOT_ECHO;
                o_ctl.res_pri    = PRI_OLD;
                o_ctl.lv_sel     = LVSEL_OLD;
                n_state          = S_HOLD;
                unique case (i_stat.cmd)
                    CMD_DEQ: begin
                        o_ctl.lv_op    = LVOP_UNLINK;
                        o_ctl.lv_sel   = LVSEL_DEQ;
                        o_ctl.lvl_wr   = 1'b1;
                        o_ctl.res_slot = SLOT_X;
                        o_ctl.res_pri  = PRI_DEQ;
                    end
                    CMD_READ: begin
                    end
                    CMD_SET: begin
                        if (!i_stat.np_ok) begin
                            o_ctl.res_status = ST_RANGE;
                        end else if (!i_stat.inq) begin
                            o_ctl.lv_sel  = LVSEL_NEW;
                            o_ctl.lvl_wr  = 1'b1;
                            o_ctl.res_pri = PRI_NEW;
                        end else begin
                            o_ctl.lv_op   = LVOP_UNLINK;
                            o_ctl.res_pri = PRI_NEW;
                            n_state       = S_APPEND;
                        end
                    end
                    CMD_ENQ: begin
                        if (i_stat.inq) begin
                            o_ctl.res_status = ST_QUEUED;
                        end else begin
                            o_ctl.lv_op   = LVOP_APPEND;
                            o_ctl.lvl_wr  = 1'b1;
                            o_ctl.lvl_inq = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_APPEND: begin
                o_ctl.lv_op   = LVOP_APPEND;
                o_ctl.lv_sel  = LVSEL_NEW;
                o_ctl.lvl_wr  = 1'b1;
                o_ctl.lvl_inq = 1'b1;
                n_state       = S_HOLD;
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== sv/mlprq_dp.sv =====
module mlprq_dp #(
    parameter int PROCESS_SLOTS   = mlprq_pkg::DEF_PROCESS_SLOTS,
    parameter int PRIORITY_LEVELS = mlprq_pkg::DEF_PRIORITY_LEVELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mlprq_pkg::t_ctl                  i_ctl,
    output mlprq_pkg::t_dp_stat              o_stat,
    input  logic [mlprq_pkg::CMD_W-1:0]      i_command,
    input  logic [mlprq_pkg::SLOT_W-1:0]     i_slot,
    input  logic [mlprq_pkg::NPRI_W-1:0]     i_req_priority,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [mlprq_pkg::STATUS_W-1:0]   o_status,
    output logic [mlprq_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [mlprq_pkg::PRI_OUT_W-1:0]  o_priority_out
);
    import mlprq_pkg::*;

    localparam int SlotW = $clog2(PROCESS_SLOTS);
    localparam int LvW   = $clog2(PRIORITY_LEVELS);
    localparam int CntW  = $clog2(PROCESS_SLOTS + 1);

    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [NPRI_W-1:0] r_np;
    logic [SlotW-1:0]  r_x;
    logic [LvW-1:0]    r_lv;
    logic              r_vld_q;

    logic [SlotW-1:0]  r_head [PRIORITY_LEVELS];
    logic [SlotW-1:0]  r_tail [PRIORITY_LEVELS];
    logic [CntW-1:0]   r_cnt  [PRIORITY_LEVELS];
    logic [PROCESS_SLOTS-1:0] r_lvl_vld;

    t_status              r_res_status;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [PRI_OUT_W-1:0] r_res_pri;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [PRI_OUT_W-1:0] r_out_pri;

    logic [PRIORITY_LEVELS-1:0] nonempty;
    logic [LvW-1:0]   enc_lv;
    logic [SlotW-1:0] fetch_addr;
    logic [SlotW-1:0] next_q;
    logic [SlotW-1:0] prev_q;
    logic [LvW:0]     lvl_rd;
    logic [LvW-1:0]   old_lv;
    logic             inq;
    logic [LvW-1:0]   lv_idx;
    logic [SlotW-1:0] cur_head;
    logic [SlotW-1:0] cur_tail;
    logic [CntW-1:0]  cur_cnt;
    logic             next_we;
    logic [SlotW-1:0] next_wa;
    logic [SlotW-1:0] next_wd;
    logic             prev_we;
    logic [SlotW-1:0] prev_wa;
    logic [SlotW-1:0] prev_wd;
    logic [LvW-1:0]   pri_lv;
    logic             out_free;

    always_comb begin
        enc_lv = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            nonempty[i] = (r_cnt[i] != '0);
            if (nonempty[i]) begin
                enc_lv = LvW'(i);
            end
        end
    end

    assign fetch_addr = (r_cmd == CMD_DEQ) ? r_head[enc_lv] : SlotW'(r_slot);

    assign old_lv = r_vld_q ? lvl_rd[LvW:1] : '0;
    assign inq    = r_vld_q & lvl_rd[0];

    always_comb begin
        case (i_ctl.lv_sel)
            LVSEL_DEQ: lv_idx = r_lv;
            LVSEL_NEW: lv_idx = LvW'(r_np);
            default:   lv_idx = old_lv;
        endcase
    end

    assign cur_head = r_head[lv_idx];
    assign cur_tail = r_tail[lv_idx];
    assign cur_cnt  = r_cnt[lv_idx];

    always_comb begin
        next_we = 1'b0;
        next_wa = r_x;
        next_wd = r_x;
        prev_we = 1'b0;
        prev_wa = r_x;
        prev_wd = r_x;
        if (i_ctl.lv_op == LVOP_UNLINK && cur_cnt != CntW'(1)
                && cur_head != r_x && cur_tail != r_x) begin
            next_we = 1'b1;
            next_wa = prev_q;
            next_wd = next_q;
            prev_we = 1'b1;
            prev_wa = next_q;
            prev_wd = prev_q;
        end else if (i_ctl.lv_op == LVOP_APPEND && cur_cnt != '0) begin
            next_we = 1'b1;
            next_wa = cur_tail;
            next_wd = r_x;
            prev_we = 1'b1;
            prev_wa = r_x;
            prev_wd = cur_tail;
        end
    end

    mlprq_ram #(.WIDTH(SlotW), .DEPTH(PROCESS_SLOTS)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (next_wa),
        .i_wr_data (next_wd),
        .i_rd_en   (i_ctl.fetch),
        .i_rd_addr (fetch_addr),
        .o_rd_data (next_q)
    );

    mlprq_ram #(.WIDTH(SlotW), .DEPTH(PROCESS_SLOTS)) u_prev_ram (
        .i_clk     (i_clk),
        .i_wr_en   (prev_we),
        .i_wr_addr (prev_wa),
        .i_wr_data (prev_wd),
        .i_rd_en   (i_ctl.fetch),
        .i_rd_addr (fetch_addr),
        .o_rd_data (prev_q)
    );

    mlprq_ram #(.WIDTH(LvW + 1), .DEPTH(PROCESS_SLOTS)) u_level_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.lvl_wr),
        .i_wr_addr (r_x),
        .i_wr_data ({lv_idx, i_ctl.lvl_inq}),
        .i_rd_en   (i_ctl.fetch),
        .i_rd_addr (fetch_addr),
        .o_rd_data (lvl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= t_cmd'(i_command);
            r_slot <= i_slot;
            r_np   <= i_req_priority;
        end
        if (i_ctl.fetch) begin
            r_x <= fetch_addr;
            r_lv <= enc_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld <= '0;
            r_vld_q   <= 1'b0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_ctl.fetch) begin
                r_vld_q <= r_lvl_vld[fetch_addr];
            end
            if (i_ctl.lvl_wr) begin
                r_lvl_vld[r_x] <= 1'b1;
            end
            case (i_ctl.lv_op)
                LVOP_UNLINK: begin
                    if (cur_cnt == CntW'(1)) begin
                        r_head[lv_idx] <= '0;
                        r_tail[lv_idx] <= '0;
                    end else if (cur_head == r_x) begin
                        r_head[lv_idx] <= next_q;
                    end else if (cur_tail == r_x) begin
                        r_tail[lv_idx] <= prev_q;
                    end
                    r_cnt[lv_idx] <= cur_cnt - CntW'(1);
                end
                LVOP_APPEND: begin
                    if (cur_cnt == '0) begin
                        r_head[lv_idx] <= r_x;
                    end
                    r_tail[lv_idx] <= r_x;
                    r_cnt[lv_idx]  <= cur_cnt + CntW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_ctl.res_pri)
            PRI_DEQ: pri_lv = r_lv;
            PRI_OLD: pri_lv = old_lv;
            PRI_NEW: pri_lv = LvW'(r_np);
            default: pri_lv = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_load) begin
            r_res_status <= i_ctl.res_status;
            r_res_pri    <= PRI_OUT_W'(pri_lv);
            case (i_ctl.res_slot)
                SLOT_ECHO: r_res_slot <= r_slot;
                SLOT_X:    r_res_slot <= SLOT_W'(r_x);
                default:   r_res_slot <= '0;
            endcase
        end
        if (i_ctl.load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_pri    <= r_res_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.cmd        = r_cmd;
    assign o_stat.slot_ok    = (int'(r_slot) < PROCESS_SLOTS);
    assign o_stat.np_ok      = (int'(r_np) <= PRIORITY_LEVELS - 1);
    assign o_stat.inq        = inq;
    assign o_stat.any_queued = |nonempty;
    assign o_stat.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_out     = r_out_slot;
    assign o_priority_out = r_out_pri;
endmodule

// ===== sv/multilevel_priority_run_queue_top.sv =====
// A command passes from acceptance through the fetch, execute and hold steps around the
// registered reads of the link and level memories; a set-priority that moves a queued slot
// adds an append step, and an empty dequeue or a slot beyond range skips the execute step.
// A finished result waits in an output register; no new command is accepted before then.
// Reset is synchronous and active low: all queues become empty, every slot reads priority
// zero and not queued, and the output channel goes idle.
module multilevel_priority_run_queue_top #(
    parameter int PROCESS_SLOTS   = mlprq_pkg::DEF_PROCESS_SLOTS,
    parameter int PRIORITY_LEVELS = mlprq_pkg::DEF_PRIORITY_LEVELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlprq_cmd_if.sink   i_cmd,
    mlprq_res_if.source o_res
);
    import mlprq_pkg::*;

    t_ctl     ctl;
    t_dp_stat stat;
    logic     in_ready;

    mlprq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    mlprq_dp #(
        .PROCESS_SLOTS   (PROCESS_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_command      (i_cmd.command),
        .i_slot         (i_cmd.slot),
        .i_req_priority (i_cmd.req_priority),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_status       (o_res.status),
        .o_slot_out     (o_res.slot_out),
        .o_priority_out (o_res.priority_out)
    );

    assign i_cmd.ready = in_ready;
endmodule

// ===== sv/mlprq_checker.sv =====
module mlprq_checker #(
    parameter int PRIORITY_LEVELS = mlprq_pkg::DEF_PRIORITY_LEVELS
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cmd_valid,
    input logic                             i_cmd_ready,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic [mlprq_pkg::STATUS_W-1:0]   i_status,
    input logic [mlprq_pkg::SLOT_W-1:0]     i_slot_out,
    input logic [mlprq_pkg::PRI_OUT_W-1:0]  i_priority_out
);
    import mlprq_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_status)
            && $stable(i_slot_out) && $stable(i_priority_out))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("New transaction accepted while a command is in progress.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_EMPTY |-> i_slot_out == '0 && i_priority_out == '0)
        else $error("Empty dequeue reported a slot or priority.");

    a_pri_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> int'(i_priority_out) < PRIORITY_LEVELS)
        else $error("Reported priority is beyond the last level.");
endmodule

bind multilevel_priority_run_queue_top mlprq_checker #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
) u_mlprq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cmd_valid    (i_cmd.valid),
    .i_cmd_ready    (i_cmd.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_status       (o_res.status),
    .i_slot_out     (o_res.slot_out),
    .i_priority_out (o_res.priority_out)
);
